@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define WFBT_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define WFBT_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/wfbt_pkg.sv @@
// Shared constants, codes and types of the worst-fit boundary tag allocator.
`default_nettype none

package wfbt_pkg;

  localparam int STORE_WORDS_DEF = 1024;
  localparam int TAG_W_DEF       = 12;

  localparam int MODE_W   = 1;
  localparam int REQ_W    = 12;
  localparam int BADDR_W  = 10;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 10;
  localparam int FREE_W   = 13;
  localparam int USED_W   = 12;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DBL    = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [PADDR_W-1:0]  paddr;
    logic [FREE_W-1:0]   free_bytes;
    logic [USED_W-1:0]   used_bytes;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/worst_fit_boundary_tag_allocator.sv @@
// Top level of the worst-fit boundary tag heap allocator.
// An allocate walks the tags of every block in the store, one block header per cycle,
// then writes the chosen block's header and footer, and on a split the remainder's tags.
// A free walks the headers up to the freed block, marks it, then merges free neighbours.
// One item is in work at a time; results are one-cycle strobes that cannot be stalled.
// After reset the tag store is cleared word by word, with busy high.
`default_nettype none

module worst_fit_boundary_tag_allocator #(
  parameter int STORE_WORDS = wfbt_pkg::STORE_WORDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [wfbt_pkg::MODE_W-1:0]         in_mode,
  input  wire logic [wfbt_pkg::REQ_W-1:0]          in_request_bytes,
  input  wire logic [wfbt_pkg::BADDR_W-1:0]        in_block_address,
  output logic                                     out_strobe,
  output logic      [wfbt_pkg::STATUS_W-1:0]       out_status,
  output logic      [wfbt_pkg::PADDR_W-1:0]        out_payload_address,
  output logic      [wfbt_pkg::FREE_W-1:0]         out_free_bytes,
  output logic      [wfbt_pkg::USED_W-1:0]         out_used_bytes
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int TW = AW + 2;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [TW-1:0]        wdata;
  logic [AW-1:0]        raddr;
  logic [TW-1:0]        rdata;
  wfbt_pkg::res_t       res;

  logic                             strobe_r;
  logic [wfbt_pkg::STATUS_W-1:0]    status_r;
  logic [wfbt_pkg::PADDR_W-1:0]     paddr_r;
  logic [wfbt_pkg::FREE_W-1:0]      free_r;
  logic [wfbt_pkg::USED_W-1:0]      used_r;

  wfbt_ram #(.WIDTH(TW), .DEPTH(STORE_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  wfbt_seq #(.STORE_WORDS(STORE_WORDS)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .mode          (in_mode),
    .request_bytes (in_request_bytes),
    .block_address (in_block_address),
    .busy          (busy),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .raddr         (raddr),
    .rdata         (rdata),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      paddr_r  <= res.paddr;
      free_r   <= res.free_bytes;
      used_r   <= res.used_bytes;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_payload_address = paddr_r;
  assign out_free_bytes      = free_r;
  assign out_used_bytes      = used_r;

endmodule

`default_nettype wire

@@ rtl/wfbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wfbt_ram #(
  parameter int WIDTH = wfbt_pkg::TAG_W_DEF,
  parameter int DEPTH = wfbt_pkg::STORE_WORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/wfbt_step.sv @@
// Shared step unit: tag magnitude, sign and base plus magnitude plus two.
`default_nettype none

module wfbt_step #(
  parameter int STORE_WORDS = wfbt_pkg::STORE_WORDS_DEF
) (
  input  wire logic [$clog2(STORE_WORDS):0]   base,
  input  wire logic [$clog2(STORE_WORDS)+1:0] tag,
  output logic      [$clog2(STORE_WORDS):0]   sum,
  output logic      [$clog2(STORE_WORDS):0]   mag,
  output logic                                neg
);

  localparam int XW = $clog2(STORE_WORDS) + 1;
  localparam int TW = XW + 1;

  logic [TW-1:0] tag_inv;

  assign neg     = tag[TW-1];
  assign tag_inv = TW'(0) - tag;
  assign mag     = neg ? tag_inv[XW-1:0] : tag[XW-1:0];
  assign sum     = base + mag + XW'(2);

endmodule

`default_nettype wire

@@ rtl/wfbt_seq.sv @@
// Sequencer and datapath: tag walks, splits, merges and the byte counters.
`default_nettype none

module wfbt_seq #(
  parameter int STORE_WORDS = wfbt_pkg::STORE_WORDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [wfbt_pkg::MODE_W-1:0]         mode,
  input  wire logic [wfbt_pkg::REQ_W-1:0]          request_bytes,
  input  wire logic [wfbt_pkg::BADDR_W-1:0]        block_address,
  output logic                                     busy,
  output logic                                     we,
  output logic      [$clog2(STORE_WORDS)-1:0]      waddr,
  output logic      [$clog2(STORE_WORDS)+1:0]      wdata,
  output logic      [$clog2(STORE_WORDS)-1:0]      raddr,
  input  wire logic [$clog2(STORE_WORDS)+1:0]      rdata,
  output wfbt_pkg::res_t                           res
);

  localparam int AW   = $clog2(STORE_WORDS);
  localparam int XW   = AW + 1;
  localparam int TW   = AW + 2;
  localparam int NW   = wfbt_pkg::REQ_W - 1;
  localparam int CW   = (XW > NW) ? XW : NW;
  localparam int CNTW = $clog2(STORE_WORDS * 4 + 1);

  localparam logic [XW-1:0] WALK_LIM = XW'(STORE_WORDS - 2);
  localparam logic [XW-1:0] STORE_X  = XW'(STORE_WORDS);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_WALK   = 5'd2;
  localparam logic [4:0] S_ADEC   = 5'd3;
  localparam logic [4:0] S_AW1    = 5'd4;
  localparam logic [4:0] S_AW2    = 5'd5;
  localparam logic [4:0] S_AW3    = 5'd6;
  localparam logic [4:0] S_DONE   = 5'd7;
  localparam logic [4:0] S_FCHK   = 5'd8;
  localparam logic [4:0] S_FHDR   = 5'd9;
  localparam logic [4:0] S_FMARK  = 5'd10;
  localparam logic [4:0] S_FMARK2 = 5'd11;
  localparam logic [4:0] S_FPREV  = 5'd12;
  localparam logic [4:0] S_FPREV2 = 5'd13;
  localparam logic [4:0] S_FNRD   = 5'd14;
  localparam logic [4:0] S_FNEXT  = 5'd15;
  localparam logic [4:0] S_FNEXT2 = 5'd16;

  function automatic logic [TW-1:0] neg_tag(input logic [XW-1:0] x);
    return TW'(0) - {1'b0, x};
  endfunction

  logic [4:0]                      state_r, state_nxt;
  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [CNTW-1:0]                 free_r, free_nxt;
  logic [CNTW-1:0]                 used_r, used_nxt;
  logic                            best_vld_r, best_vld_nxt;
  logic [XW-1:0]                   i_r, i_nxt;
  logic [XW-1:0]                   idx_r, idx_nxt;
  logic [XW-1:0]                   size_r, size_nxt;
  logic [XW-1:0]                   best_r, best_nxt;
  logic [XW-1:0]                   bsize_r, bsize_nxt;
  logic [XW-1:0]                   take_r, take_nxt;
  logic [NW-1:0]                   need_r, need_nxt;
  logic [wfbt_pkg::STATUS_W-1:0]   st_r, st_nxt;
  logic [wfbt_pkg::PADDR_W-1:0]    pa_r, pa_nxt;

  logic [XW-1:0]                   step_base, step_sum, step_mag;
  logic                            step_neg;
  logic [wfbt_pkg::REQ_W:0]        req_sum;
  logic [NW-1:0]                   need_raw;
  logic [CW-1:0]                   left;
  logic                            split;
  logic [XW-1:0]                   take;
  logic [XW-1:0]                   foot_addr;
  logic [XW-1:0]                   next_addr;
  logic [XW-1:0]                   rem;
  logic [XW-1:0]                   prev_idx;
  logic                            fits;

  wfbt_step #(.STORE_WORDS(STORE_WORDS)) u_step (
    .base (step_base),
    .tag  (rdata),
    .sum  (step_sum),
    .mag  (step_mag),
    .neg  (step_neg)
  );

  assign step_base = (state_r == S_WALK || state_r == S_FHDR) ? i_r : size_r;
  assign req_sum   = {1'b0, request_bytes} + (wfbt_pkg::REQ_W + 1)'(3);
  assign need_raw  = req_sum[wfbt_pkg::REQ_W:2];
  assign left      = CW'(bsize_r) - CW'(need_r);
  assign split     = left >= CW'(3);
  assign take      = split ? XW'(need_r) : bsize_r;
  assign foot_addr = idx_r + size_r + XW'(1);
  assign next_addr = idx_r + size_r + XW'(2);
  assign rem       = bsize_r - take_r - XW'(2);
  assign prev_idx  = idx_r - step_mag - XW'(2);
  assign fits      = step_neg && (CW'(step_mag) >= CW'(need_r)) &&
                     (!best_vld_r || step_mag > bsize_r);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    free_nxt     = free_r;
    used_nxt     = used_r;
    best_vld_nxt = best_vld_r;
    i_nxt        = i_r;
    idx_nxt      = idx_r;
    size_nxt     = size_r;
    best_nxt     = best_r;
    bsize_nxt    = bsize_r;
    take_nxt     = take_r;
    need_nxt     = need_r;
    st_nxt       = st_r;
    pa_nxt       = pa_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = (clr_r == '0 || clr_r == AW'(STORE_WORDS - 1)) ?
                neg_tag(WALK_LIM) : '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          pa_nxt = '0;
          st_nxt = wfbt_pkg::ST_OK;
          if (mode == wfbt_pkg::MODE_ALLOC) begin
            need_nxt     = (need_raw == '0) ? NW'(1) : need_raw;
            best_vld_nxt = 1'b0;
            i_nxt        = '0;
            raddr        = '0;
            state_nxt    = S_WALK;
          end else if (block_address == '0 || int'(block_address) > STORE_WORDS) begin
            st_nxt    = wfbt_pkg::ST_BOUNDS;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = XW'(block_address) - XW'(1);
            raddr     = AW'(block_address - wfbt_pkg::BADDR_W'(1));
            state_nxt = S_FCHK;
          end
        end
      end
      S_WALK: begin
        if (fits) begin
          best_vld_nxt = 1'b1;
          best_nxt     = i_r;
          bsize_nxt    = step_mag;
        end
        i_nxt = step_sum;
        if (step_sum < WALK_LIM) begin
          raddr = step_sum[AW-1:0];
        end else begin
          state_nxt = S_ADEC;
        end
      end
      S_ADEC: begin
        if (!best_vld_r) begin
          st_nxt    = wfbt_pkg::ST_NOFIT;
          state_nxt = S_DONE;
        end else begin
          we       = 1'b1;
          waddr    = best_r[AW-1:0];
          wdata    = {1'b0, take};
          take_nxt = take;
          free_nxt = free_r - CNTW'({take, 2'b00}) - (split ? CNTW'(8) : CNTW'(0));
          used_nxt = used_r + CNTW'({take, 2'b00});
          pa_nxt   = wfbt_pkg::PADDR_W'(best_r + XW'(1));
          state_nxt = S_AW1;
        end
      end
      S_AW1: begin
        we    = 1'b1;
        waddr = AW'(best_r + take_r + XW'(1));
        wdata = {1'b0, take_r};
        state_nxt = (take_r == bsize_r) ? S_DONE : S_AW2;
      end
      S_AW2: begin
        we    = 1'b1;
        waddr = AW'(best_r + take_r + XW'(2));
        wdata = neg_tag(rem);
        state_nxt = S_AW3;
      end
      S_AW3: begin
        we    = 1'b1;
        waddr = AW'(best_r + bsize_r + XW'(1));
        wdata = neg_tag(rem);
        state_nxt = S_DONE;
      end
      S_FCHK: begin
        if (step_neg || rdata == '0) begin
          st_nxt    = wfbt_pkg::ST_DBL;
          state_nxt = S_DONE;
        end else begin
          size_nxt = rdata[XW-1:0];
          i_nxt    = '0;
          if (idx_r == '0) begin
            state_nxt = S_FMARK;
          end else begin
            raddr     = '0;
            state_nxt = S_FHDR;
          end
        end
      end
      S_FHDR: begin
        i_nxt = step_sum;
        if (!(step_sum < WALK_LIM) || step_sum > idx_r) begin
          st_nxt    = wfbt_pkg::ST_BOUNDS;
          state_nxt = S_DONE;
        end else if (step_sum == idx_r) begin
          state_nxt = S_FMARK;
        end else begin
          raddr = step_sum[AW-1:0];
        end
      end
      S_FMARK: begin
        we       = 1'b1;
        waddr    = idx_r[AW-1:0];
        wdata    = neg_tag(size_r);
        used_nxt = used_r - CNTW'({size_r, 2'b00});
        free_nxt = free_r + CNTW'({size_r, 2'b00});
        state_nxt = S_FMARK2;
      end
      S_FMARK2: begin
        we    = 1'b1;
        waddr = foot_addr[AW-1:0];
        wdata = neg_tag(size_r);
        if (idx_r > XW'(2)) begin
          raddr     = AW'(idx_r - XW'(1));
          state_nxt = S_FPREV;
        end else begin
          state_nxt = S_FNRD;
        end
      end
      S_FPREV: begin
        if (step_neg) begin
          we       = 1'b1;
          waddr    = prev_idx[AW-1:0];
          wdata    = neg_tag(step_sum);
          idx_nxt  = prev_idx;
          size_nxt = step_sum;
          free_nxt = free_r + CNTW'(8);
          state_nxt = S_FPREV2;
        end else begin
          state_nxt = S_FNRD;
        end
      end
      S_FPREV2: begin
        we    = 1'b1;
        waddr = foot_addr[AW-1:0];
        wdata = neg_tag(size_r);
        state_nxt = S_FNRD;
      end
      S_FNRD: begin
        if (next_addr < STORE_X) begin
          raddr     = next_addr[AW-1:0];
          state_nxt = S_FNEXT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FNEXT: begin
        if (step_neg) begin
          we       = 1'b1;
          waddr    = idx_r[AW-1:0];
          wdata    = neg_tag(step_sum);
          size_nxt = step_sum;
          free_nxt = free_r + CNTW'(8);
          state_nxt = S_FNEXT2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FNEXT2: begin
        we    = 1'b1;
        waddr = foot_addr[AW-1:0];
        wdata = neg_tag(size_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      free_r     <= CNTW'((STORE_WORDS - 2) * 4);
      used_r     <= '0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      free_r     <= free_nxt;
      used_r     <= used_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    idx_r   <= idx_nxt;
    size_r  <= size_nxt;
    best_r  <= best_nxt;
    bsize_r <= bsize_nxt;
    take_r  <= take_nxt;
    need_r  <= need_nxt;
    st_r    <= st_nxt;
    pa_r    <= pa_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign res.valid      = (state_r == S_DONE);
  assign res.status     = st_r;
  assign res.paddr      = pa_r;
  assign res.free_bytes = wfbt_pkg::FREE_W'(free_r);
  assign res.used_bytes = wfbt_pkg::USED_W'(used_r);

endmodule

`default_nettype wire

@@ rtl/wfbt_chk.sv @@
// Port-level checker for the allocator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module wfbt_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              out_strobe,
  input wire logic [wfbt_pkg::STATUS_W-1:0]     out_status,
  input wire logic [wfbt_pkg::PADDR_W-1:0]      out_payload_address
);

  // An accepted item keeps the block busy in the following cycle.
  `WFBT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // A result is only shown once the block has gone idle.
  `WFBT_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  // Results never come in consecutive cycles.
  `WFBT_ASSERT_NXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  // A failed item reports no payload address.
  `WFBT_ASSERT_IMP(a_fail_no_addr, clk, rst_n,
    out_strobe && out_status != wfbt_pkg::ST_OK, out_payload_address == '0)

endmodule

bind worst_fit_boundary_tag_allocator wfbt_chk u_wfbt_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_status          (out_status),
  .out_payload_address (out_payload_address)
);

`default_nettype wire
